[rtl/fdct_pkg.sv]
// Package: constants, types and cosine table for the 8x8 forward DCT.
package fdct_pkg;

  localparam int CosFracBits = 14;
  localparam int RowFracBits = 4;
  localparam int CosW  = CosFracBits + 2;
  localparam int RowW  = 20;
  localparam int AccW  = 48;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ROW,
    ST_ROW_WB,
    ST_COL,
    ST_COL_OUT
  } fdct_state_t;

  typedef struct packed {
    logic       clr;
    logic       en;
    logic [2:0] k;
    logic [2:0] n;
  } mac_ctrl_t;

  // Round-half-up of a Q32 magnitude to CosFracBits fraction bits.
  function automatic logic signed [CosW-1:0] q32_round(input logic [31:0] mag);
    logic [32:0] t;
    t = {1'b0, mag} + (33'd1 << (31 - CosFracBits));
    return CosW'(t >> (32 - CosFracBits));
  endfunction

  // Cosine factor c(k)*cos((2n+1)k*pi/16).
  function automatic logic signed [CosW-1:0] cos_coef(input logic [2:0] k,
                                                      input logic [2:0] n);
    logic [4:0]  m;
    logic        neg;
    logic [31:0] mag;
    logic signed [CosW-1:0] r;
    m   = 5'(k * (2 * n + 1));
    neg = 1'b0;
    if (m > 5'd16) m = 5'd0 - m;
    if (m > 5'd8) begin
      m   = 5'd16 - m;
      neg = 1'b1;
    end
    if (k == 3'd0) mag = 32'd1518500250;
    else begin
      unique case (m[3:0])
        4'd0:    mag = 32'd2147483648;
        4'd1:    mag = 32'd2106220352;
        4'd2:    mag = 32'd1984016189;
        4'd3:    mag = 32'd1785567396;
        4'd4:    mag = 32'd1518500250;
        4'd5:    mag = 32'd1193077991;
        4'd6:    mag = 32'd821806413;
        4'd7:    mag = 32'd418953276;
        default: mag = 32'd0;
      endcase
    end
    r = q32_round(mag);
    return neg ? -r : r;
  endfunction

endpackage

[rtl/fdct_ram.sv]
// Generic single-port-write, registered-read RAM.
module fdct_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/fdct_mac.sv]
// Shared multiply-accumulate unit: cosine times operand, registered product.
module fdct_mac (
  input  logic                             clk,
  input  fdct_pkg::mac_ctrl_t              ctrl,
  input  logic signed [fdct_pkg::RowW-1:0] operand,
  output logic signed [fdct_pkg::AccW-1:0] acc
);
  import fdct_pkg::*;

  logic signed [CosW+RowW-1:0] prod;
  logic                        prod_vld;
  logic                        prod_clr;

  // stage 1: product
  always_ff @(posedge clk) begin
    prod     <= cos_coef(ctrl.k, ctrl.n) * operand;
    prod_vld <= ctrl.en;
    prod_clr <= ctrl.clr;
  end

  // stage 2: accumulate
  always_ff @(posedge clk) begin
    if (prod_vld) begin
      if (prod_clr) acc <= AccW'(prod);
      else          acc <= acc + AccW'(prod);
    end
  end
endmodule

[rtl/forward_dct_8x8_level_shift_unit.sv]
// Top level: 8x8 forward DCT with level shift, one shared MAC under a sequencer.
// Loading takes one sample per cycle while start is high; after the 64th, busy rises for the transform.
// Row pass: 64 sums of 8 products, each as 8 reads, a drain, then a write-back.
// Column pass likewise, with each sum ending in a coefficient strobe.
// A new block is loaded only once the previous block has been fully output.
// Reset (rst, synchronous) returns to loading with the sample count at zero.
module forward_dct_8x8_level_shift_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         sample_in,
  output logic               strobe,
  output logic signed [10:0] coefficient,
  output logic [5:0]         coef_index,
  output logic               block_last
);
  import fdct_pkg::*;

  fdct_state_t state, state_next;
  logic [5:0]  cnt, cnt_next;      // sample count / output index (v,u) or (u,y)
  logic [3:0]  step, step_next;    // product step within one sum

  logic [7:0]  s_rdata;
  logic signed [RowW-1:0] r_rdata, r_wdata;
  logic [5:0]  s_raddr, r_raddr;
  logic        r_we;
  mac_ctrl_t   ctrl;
  logic signed [RowW-1:0] operand;
  logic signed [AccW-1:0] acc;
  logic        col_phase;

  fdct_ram #(.Width(8), .Depth(64)) u_samples (
    .clk, .we(state == ST_LOAD && start), .waddr(cnt), .wdata(sample_in),
    .raddr(s_raddr), .rdata(s_rdata));

  fdct_ram #(.Width(RowW), .Depth(64)) u_rows (
    .clk, .we(r_we), .waddr(cnt), .wdata(r_wdata), .raddr(r_raddr), .rdata(r_rdata));

  fdct_mac u_mac (.clk, .ctrl, .operand, .acc);

  // Addresses: row pass reads s[x + 8y], cnt = {u,y}; column reads R[u*8+y], cnt = {v,u}
  assign s_raddr = {cnt[2:0], step[2:0]};
  assign r_raddr = {cnt[2:0], step[2:0]};
  assign col_phase = (state == ST_COL);
  assign operand = col_phase ? r_rdata : RowW'($signed({1'b0, s_rdata}) - 10'sd128);

  // MAC control lags the read into the next cycle (registered RAM read)
  always_ff @(posedge clk) begin
    if (rst) ctrl <= '0;
    else begin
      ctrl.en  <= (state == ST_ROW || state == ST_COL) && step < 4'd8;
      ctrl.clr <= step == 4'd0;
      ctrl.k   <= cnt[5:3];
      ctrl.n   <= step[2:0];
    end
  end

  // Rounding and saturation of finished sums
  logic signed [AccW-1:0] row_r, col_r;
  always_comb begin
    row_r = (acc + (AccW'(1) <<< (CosFracBits - RowFracBits - 1)))
            >>> (CosFracBits - RowFracBits);
    col_r = (acc + (AccW'(1) <<< (CosFracBits + RowFracBits - 1)))
            >>> (CosFracBits + RowFracBits);
    if (row_r > 524287)       r_wdata = 20'sd524287;
    else if (row_r < -524288) r_wdata = RowW'(-524288);
    else                      r_wdata = RowW'(row_r);
  end
  assign r_we = (state == ST_ROW_WB);

  // Sequencer. Sum is ready once the last read issue (step 7) has passed the RAM read,
  // product and accumulator registers, in the write-back or output cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      cnt   <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    step_next  = step;
    unique case (state)
      ST_LOAD: begin
        if (start) begin
          cnt_next = cnt + 6'd1;
          if (cnt == 6'd63) begin
            state_next = ST_ROW;
            step_next  = '0;
          end
        end
      end
      ST_ROW: begin
        step_next = step + 4'd1;
        if (step == 4'd9) state_next = ST_ROW_WB;
      end
      ST_ROW_WB: begin
        cnt_next  = cnt + 6'd1;
        step_next = '0;
        state_next = (cnt == 6'd63) ? ST_COL : ST_ROW;
      end
      ST_COL: begin
        step_next = step + 4'd1;
        if (step == 4'd9) state_next = ST_COL_OUT;
      end
      ST_COL_OUT: begin
        cnt_next  = cnt + 6'd1;
        step_next = '0;
        state_next = (cnt == 6'd63) ? ST_LOAD : ST_COL;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // column pass: cnt = {v, u}; R address must be u*8+y
  // (remapped: r_raddr uses cnt[2:0]=u, k=cnt[5:3]=v) -- matches the above.

  assign busy   = (state != ST_LOAD);
  assign strobe = (state == ST_COL_OUT);
  assign coef_index = {cnt[5:3], cnt[2:0]};
  assign block_last = strobe && cnt == 6'd63;
  always_comb begin
    if (col_r > 1023)       coefficient = 11'sd1023;
    else if (col_r < -1024) coefficient = 11'(-1024);
    else                    coefficient = 11'(col_r);
  end
endmodule
